@@ rtl/core/assert_macros.svh @@
// assertion helpers shared by the core modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property holds at every clock edge outside reset
`define FLT_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// consequent holds in the cycle after the antecedent
`define FLT_ASSERT_NEXT(lbl, clk, rst, pre, post, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);

`endif

@@ rtl/core/flt_pkg.sv @@
`timescale 1ns / 1ps
package flt_pkg;

   localparam int DATA_BITS = 31;
   localparam int CNT_BITS  = $clog2(DATA_BITS);

   localparam logic [CNT_BITS-1:0] DIV_LAST = CNT_BITS'(DATA_BITS - 1);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_GCD,
      ST_DIV,
      ST_DONE
   } ctrl_state_type;

   typedef struct packed {
      logic load;
      logic gcd_step;
      logic div_init;
      logic div_step;
   } dp_cmd_type;

   typedef struct packed {
      logic den_zero;
      logic gcd_done;
      logic div_last;
   } dp_status_type;

endpackage

@@ rtl/core/flt_ctrl.sv @@
`timescale 1ns / 1ps
`include "assert_macros.svh"
module flt_ctrl
   import flt_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   output logic          busy,
   output logic          rsp_valid,
   output dp_cmd_type    cmd,
   input  dp_status_type status
);

   ctrl_state_type state_ff;
   ctrl_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      busy      = 1'b1;
      rsp_valid = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            busy = 1'b0;
            if (start) begin
               cmd.load = 1'b1;
               state_in = ST_GCD;
            end
         end
         ST_GCD: begin
            if (status.den_zero) begin
               state_in = ST_DONE;
            end else if (status.gcd_done) begin
               cmd.div_init = 1'b1;
               state_in     = ST_DIV;
            end else begin
               cmd.gcd_step = 1'b1;
            end
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (status.div_last) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            rsp_valid = 1'b1;
            state_in  = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   `FLT_ASSERT_NEXT(a_rsp_single, clock, reset, rsp_valid, !rsp_valid, "result strobe held")
   `FLT_ASSERT_NEXT(a_accept_busy, clock, reset, start && !busy, busy, "accepted beat not busy")
   `FLT_ASSERT(a_one_cmd, clock, reset, $onehot0(cmd), "more than one datapath command")

endmodule

@@ rtl/core/flt_dp.sv @@
`timescale 1ns / 1ps
`include "assert_macros.svh"
module flt_dp
   import flt_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  dp_cmd_type           cmd,
   output dp_status_type        status,
   input  logic [DATA_BITS-1:0] req_num_in,
   input  logic [DATA_BITS-1:0] req_den_in,
   output logic [DATA_BITS-1:0] rsp_num_out,
   output logic [DATA_BITS-1:0] rsp_den_out,
   output logic [DATA_BITS-1:0] rsp_common_divisor,
   output logic                 rsp_zero_den_error
);

   logic [DATA_BITS-1:0] a_ff, a_in, b_ff, b_in;
   logic [CNT_BITS-1:0]  k_ff, k_in;
   logic [DATA_BITS-1:0] num_ff, num_in, den_ff, den_in;
   logic [DATA_BITS-1:0] g_ff, g_in;
   logic [DATA_BITS-1:0] rem_n_ff, rem_n_in, q_n_ff, q_n_in;
   logic [DATA_BITS-1:0] rem_d_ff, rem_d_in, q_d_ff, q_d_in;
   logic [CNT_BITS-1:0]  cnt_ff, cnt_in;
   logic                 err_ff, err_in;

   logic                 a_ge_b;
   logic [DATA_BITS-1:0] diff;
   logic [DATA_BITS:0]   g_ext, trial_n, trial_d;
   logic                 fit_n, fit_d;

   // binary gcd step
   assign a_ge_b = a_ff >= b_ff;
   assign diff   = a_ge_b ? (a_ff - b_ff) : (b_ff - a_ff);

   // restoring division of both parts by the divisor
   assign g_ext   = {1'b0, g_ff};
   assign trial_n = {rem_n_ff, q_n_ff[DATA_BITS-1]};
   assign trial_d = {rem_d_ff, q_d_ff[DATA_BITS-1]};
   assign fit_n   = trial_n >= g_ext;
   assign fit_d   = trial_d >= g_ext;

   always_comb begin
      a_in     = a_ff;
      b_in     = b_ff;
      k_in     = k_ff;
      num_in   = num_ff;
      den_in   = den_ff;
      g_in     = g_ff;
      rem_n_in = rem_n_ff;
      q_n_in   = q_n_ff;
      rem_d_in = rem_d_ff;
      q_d_in   = q_d_ff;
      cnt_in   = cnt_ff;
      err_in   = err_ff;
      if (cmd.load) begin
         a_in   = req_num_in;
         b_in   = req_den_in;
         k_in   = '0;
         num_in = req_num_in;
         den_in = req_den_in;
         err_in = (req_den_in == '0);
      end
      if (cmd.gcd_step) begin
         if (!a_ff[0] && !b_ff[0]) begin
            a_in = a_ff >> 1;
            b_in = b_ff >> 1;
            k_in = k_ff + CNT_BITS'(1);
         end else if (!a_ff[0]) begin
            a_in = a_ff >> 1;
         end else if (!b_ff[0]) begin
            b_in = b_ff >> 1;
         end else if (a_ge_b) begin
            a_in = diff >> 1;
         end else begin
            b_in = diff >> 1;
         end
      end
      if (cmd.div_init) begin
         // one of a and b is zero here
         g_in     = (a_ff | b_ff) << k_ff;
         rem_n_in = '0;
         q_n_in   = num_ff;
         rem_d_in = '0;
         q_d_in   = den_ff;
         cnt_in   = '0;
      end
      if (cmd.div_step) begin
         rem_n_in = fit_n ? DATA_BITS'(trial_n - g_ext) : trial_n[DATA_BITS-1:0];
         rem_d_in = fit_d ? DATA_BITS'(trial_d - g_ext) : trial_d[DATA_BITS-1:0];
         q_n_in   = {q_n_ff[DATA_BITS-2:0], fit_n};
         q_d_in   = {q_d_ff[DATA_BITS-2:0], fit_d};
         cnt_in   = cnt_ff + CNT_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
         err_ff <= 1'b0;
      end else begin
         cnt_ff <= cnt_in;
         err_ff <= err_in;
      end
   end

   always_ff @(posedge clock) begin
      a_ff     <= a_in;
      b_ff     <= b_in;
      k_ff     <= k_in;
      num_ff   <= num_in;
      den_ff   <= den_in;
      g_ff     <= g_in;
      rem_n_ff <= rem_n_in;
      q_n_ff   <= q_n_in;
      rem_d_ff <= rem_d_in;
      q_d_ff   <= q_d_in;
   end

   assign status.den_zero = err_ff;
   assign status.gcd_done = (a_ff == '0) || (b_ff == '0);
   assign status.div_last = (cnt_ff == DIV_LAST);

   assign rsp_num_out        = err_ff ? '0 : q_n_ff;
   assign rsp_den_out        = err_ff ? '0 : q_d_ff;
   assign rsp_common_divisor = err_ff ? '0 : g_ff;
   assign rsp_zero_den_error = err_ff;

   `FLT_ASSERT(a_gcd_nonzero, clock, reset, !cmd.gcd_step || !status.gcd_done, "gcd step at end")
   `FLT_ASSERT(a_rem_n_below, clock, reset, !cmd.div_step || rem_n_ff < g_ff, "num remainder")
   `FLT_ASSERT(a_rem_d_below, clock, reset, !cmd.div_step || rem_d_ff < g_ff, "den remainder")

endmodule

@@ rtl/core/fraction_lowest_terms.sv @@
// fraction_lowest_terms: reduces num/den to lowest terms.
// input: pulse start with req_num_in and req_den_in while busy is low;
// the beat is taken at that edge and busy stays high until the result.
// output: rsp_valid is high for exactly one cycle with rsp_num_out,
// rsp_den_out, rsp_common_divisor and rsp_zero_den_error; the receiver
// must take the beat in that cycle, it cannot stall the block.
// a zero denominator flags rsp_zero_den_error with all other fields zero,
// and the block then goes from the gcd state straight to the done state.
// otherwise the divisor comes from a binary gcd loop, one shift or one
// subtract-and-shift per cycle, followed by restoring division over all
// 31 quotient bits, both parts divided side by side.
// one fraction is in flight at a time; a new start can be taken in the
// cycle after the strobe.
// synchronous active-high reset returns the block to idle with no result
// pending; no clearing pass is needed.
`timescale 1ns / 1ps
module fraction_lowest_terms
   import flt_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  logic [DATA_BITS-1:0] req_num_in,
   input  logic [DATA_BITS-1:0] req_den_in,
   output logic                 rsp_valid,
   output logic [DATA_BITS-1:0] rsp_num_out,
   output logic [DATA_BITS-1:0] rsp_den_out,
   output logic [DATA_BITS-1:0] rsp_common_divisor,
   output logic                 rsp_zero_den_error
);

   dp_cmd_type    cmd;
   dp_status_type status;

   flt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .cmd       (cmd),
      .status    (status)
   );

   flt_dp u_dp (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .status             (status),
      .req_num_in         (req_num_in),
      .req_den_in         (req_den_in),
      .rsp_num_out        (rsp_num_out),
      .rsp_den_out        (rsp_den_out),
      .rsp_common_divisor (rsp_common_divisor),
      .rsp_zero_den_error (rsp_zero_den_error)
   );

endmodule

@@ tb/sv/fraction_lowest_terms_tb.sv @@
`timescale 1ns / 1ps
module fraction_lowest_terms_tb;
   import flt_pkg::*;

   localparam int RANDOM_PER_PHASE = 475;
   localparam int PHASE_COUNT = 4;
   localparam int SETTLE_CYCLES = 120;

   typedef struct packed {
      bit [DATA_BITS-1:0] num;
      bit [DATA_BITS-1:0] den;
   } fraction_item_t;

   typedef struct packed {
      bit [DATA_BITS-1:0] num;
      bit [DATA_BITS-1:0] den;
      bit [DATA_BITS-1:0] divisor;
      bit                 den_zero;
   } reduced_fraction_t;

   localparam bit [DATA_BITS-1:0] FIELD_MAX = {DATA_BITS{1'b1}};

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 start = 1'b0;
   logic                 busy;
   logic [DATA_BITS-1:0] req_num_in = '0;
   logic [DATA_BITS-1:0] req_den_in = '0;
   logic                 rsp_valid;
   logic [DATA_BITS-1:0] rsp_num_out;
   logic [DATA_BITS-1:0] rsp_den_out;
   logic [DATA_BITS-1:0] rsp_common_divisor;
   logic                 rsp_zero_den_error;

   fraction_item_t    pending_fractions[$];
   reduced_fraction_t reduced_expect[$];

   int unsigned sender_idle_pct = 0;
   int unsigned mismatch_count = 0;
   int unsigned fractions_sent = 0;
   int unsigned fractions_checked = 0;
   int unsigned zero_den_sent = 0;
   int unsigned zero_num_sent = 0;

   fraction_lowest_terms uut (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_num_in         (req_num_in),
      .req_den_in         (req_den_in),
      .rsp_valid          (rsp_valid),
      .rsp_num_out        (rsp_num_out),
      .rsp_den_out        (rsp_den_out),
      .rsp_common_divisor (rsp_common_divisor),
      .rsp_zero_den_error (rsp_zero_den_error)
   );

   always #6 clock = ~clock;

   function automatic reduced_fraction_t reduce_fraction(bit [DATA_BITS-1:0] n,
                                                         bit [DATA_BITS-1:0] d);
      reduced_fraction_t r;
      bit [DATA_BITS-1:0] a;
      bit [DATA_BITS-1:0] b;
      bit [DATA_BITS-1:0] t;
      r = '0;
      if (d == 0) begin
         r.den_zero = 1'b1;
         return r;
      end
      a = n;
      b = d;
      while (b != 0) begin
         t = a % b;
         a = b;
         b = t;
      end
      r.divisor = a;
      r.num = n / a;
      r.den = d / a;
      return r;
   endfunction

   function automatic fraction_item_t random_fraction();
      fraction_item_t f;
      int unsigned pick;
      bit [31:0] g;
      bit [31:0] k;
      int unsigned sh;
      pick = $urandom_range(0, 99);
      f.num = DATA_BITS'($urandom());
      f.den = DATA_BITS'($urandom());
      if (pick < 35) begin
         // full-width values, keep as drawn
      end else if (pick < 60) begin
         // shared factor g, so the divisor is a multiple of g
         g = $urandom_range(1, 65535);
         f.num = DATA_BITS'(g * $urandom_range(0, 32767));
         f.den = DATA_BITS'(g * $urandom_range(1, 32767));
      end else if (pick < 70) begin
         f.num = DATA_BITS'($urandom_range(0, 255));
         f.den = DATA_BITS'($urandom_range(0, 255));
      end else if (pick < 78) begin
         f.num = '0;
         if (f.den == 0)
            f.den = 1;
      end else if (pick < 83) begin
         f.den = '0;
      end else if (pick < 90) begin
         // numerator a multiple of the denominator
         f.den = DATA_BITS'($urandom_range(1, 65535));
         k = $urandom_range(1, 32767);
         f.num = DATA_BITS'(k * f.den);
      end else begin
         sh = $urandom_range(0, DATA_BITS - 1);
         f.num = f.num << sh;
         sh = $urandom_range(0, DATA_BITS - 1);
         f.den = f.den << sh;
         if (f.den == 0)
            f.den = DATA_BITS'(1) << (DATA_BITS - 1);
      end
      return f;
   endfunction

   task automatic queue_fraction(bit [DATA_BITS-1:0] n, bit [DATA_BITS-1:0] d);
      fraction_item_t f;
      f.num = n;
      f.den = d;
      pending_fractions.push_back(f);
   endtask

   task automatic check_field(string name, bit [DATA_BITS-1:0] want,
                              logic [DATA_BITS-1:0] got);
      if (got !== want) begin
         $display("%0t: %s expected %0d got %0d", $time, name, want, got);
         mismatch_count++;
      end
   endtask

   // driver: one beat on the request ports at a time
   always @(posedge clock) begin
      fraction_item_t item;
      bit next_start;
      if (reset) begin
         start <= 1'b0;
         req_num_in <= '0;
         req_den_in <= '0;
      end else begin
         next_start = start;
         if (start && !busy) begin
            reduced_expect.push_back(reduce_fraction(req_num_in, req_den_in));
            fractions_sent++;
            if (req_den_in == 0)
               zero_den_sent++;
            else if (req_num_in == 0)
               zero_num_sent++;
            next_start = 1'b0;
         end
         if (!next_start && pending_fractions.size() != 0
             && $urandom_range(0, 99) >= sender_idle_pct) begin
            item = pending_fractions.pop_front();
            req_num_in <= item.num;
            req_den_in <= item.den;
            next_start = 1'b1;
         end
         start <= next_start;
      end
   end

   // monitor: every strobed beat is checked against the oldest prediction
   always @(posedge clock) begin
      reduced_fraction_t want;
      if (!reset && rsp_valid) begin
         if (reduced_expect.size() == 0) begin
            $display("%0t: unexpected result num %0d den %0d divisor %0d error %0b",
                     $time, rsp_num_out, rsp_den_out, rsp_common_divisor,
                     rsp_zero_den_error);
            mismatch_count++;
         end else begin
            want = reduced_expect.pop_front();
            check_field("rsp_num_out", want.num, rsp_num_out);
            check_field("rsp_den_out", want.den, rsp_den_out);
            check_field("rsp_common_divisor", want.divisor, rsp_common_divisor);
            check_field("rsp_zero_den_error", DATA_BITS'(want.den_zero),
                        DATA_BITS'(rsp_zero_den_error));
            fractions_checked++;
         end
      end
   end

   initial begin
      int unsigned phase_idle[PHASE_COUNT];
      phase_idle[0] = 0;
      phase_idle[1] = 79;
      phase_idle[2] = 38;
      phase_idle[3] = 0;

      // directed corners
      queue_fraction(0, 0);
      queue_fraction(1, 0);
      queue_fraction(FIELD_MAX, 0);
      queue_fraction(0, 1);
      queue_fraction(0, 12);
      queue_fraction(0, FIELD_MAX);
      queue_fraction(1, 1);
      queue_fraction(FIELD_MAX, FIELD_MAX);
      queue_fraction(FIELD_MAX, 1);
      queue_fraction(1, FIELD_MAX);
      queue_fraction(FIELD_MAX, FIELD_MAX - DATA_BITS'(1));
      queue_fraction(12, 18);
      queue_fraction(18, 12);
      queue_fraction(31'd1836311903, 31'd1134903170);
      queue_fraction(31'd1134903170, 31'd1836311903);
      queue_fraction(31'h4000_0000, 31'h4000_0000);
      queue_fraction(31'h4000_0000, 31'h6000_0000);
      queue_fraction(31'h4000_0000, 1);
      queue_fraction(1, 31'h4000_0000);
      queue_fraction(31'h2AAA_AAAA, 31'h5555_5555);
      queue_fraction(31'd2147395599, 31'd46340);

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      for (int p = 0; p < PHASE_COUNT; p++) begin
         @(negedge clock);
         sender_idle_pct = phase_idle[p];
         for (int i = 0; i < RANDOM_PER_PHASE; i++)
            pending_fractions.push_back(random_fraction());
         // hold off until the block has drained completely
         while (pending_fractions.size() != 0 || start || reduced_expect.size() != 0)
            @(negedge clock);
      end

      repeat (SETTLE_CYCLES) @(negedge clock);
      if (reduced_expect.size() != 0) begin
         $display("%0t: %0d results never arrived", $time, reduced_expect.size());
         mismatch_count++;
      end
      $display("tb: %0d fractions sent, %0d results checked, %0d mismatches",
               fractions_sent, fractions_checked, mismatch_count);
      $display("tb: %0d zero denominators, %0d zero numerators, idle levels 0/79/38",
               zero_den_sent, zero_num_sent);
      if (mismatch_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

   initial begin
      #12_000_000;
      $display("%0t: timeout", $time);
      $display("tb: failure");
      $finish;
   end

endmodule
